### rtl/pfa_pkg.sv
// pfa_pkg: shared types, constants and helper functions of the page frame allocator
// used by the channel interfaces, the frame search, the core and its checker
package pfa_pkg;

  // configuration defaults
  localparam int PFA_FRAME_COUNT = 32;

  // field widths fixed by the channel format
  localparam int CMD_W      = 2;
  localparam int FIDX_W     = 10;
  localparam int AMOUNT_W   = 32;
  localparam int FREE_W     = 5;
  localparam int NEED_W     = 11;
  localparam int FRAME_SHIFT = 22;

  // page directory geometry
  localparam int DIR_DEPTH = 1024;
  localparam int DIR_AW    = 10;
  localparam int ENTRY_W   = 14;
  localparam logic [DIR_AW-1:0] KERNEL_LOW_IDX  = 10'h000;
  localparam logic [DIR_AW-1:0] KERNEL_HIGH_IDX = 10'h300;

  // used-bit map is held as rows of 32 frames
  localparam int ROW_W     = 32;
  localparam int ROW_SHIFT = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CHECK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd2;

  // directory entry layout
  localparam logic [ENTRY_W-1:0] E_PRESENT = 14'h0001;
  localparam logic [ENTRY_W-1:0] E_WRITE   = 14'h0002;
  localparam logic [ENTRY_W-1:0] E_USER    = 14'h0004;
  localparam logic [ENTRY_W-1:0] E_PS4MB   = 14'h0008;
  localparam int E_FRAME_SHIFT = 4;
  localparam logic [ENTRY_W-1:0] E_KERNEL  = E_PRESENT | E_WRITE | E_PS4MB;
  localparam logic [ENTRY_W-1:0] E_ALLOC   = E_PRESENT | E_WRITE | E_USER | E_PS4MB;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_A_READ,
    S_A_SCAN,
    S_F_READ,
    S_F_ENTRY,
    S_F_BITMAP,
    S_RESULT
  } state_t;

  // outcome of the lowest-free search over one row
  typedef struct packed {
    logic                 found;
    logic [ROW_SHIFT-1:0] pos;
  } find_t;

  // reset image of one bitmap row: frame 0 and frames past the map read as used
  function automatic logic [ROW_W-1:0] row_init(input int unsigned row,
                                                input int unsigned frames);
    logic [ROW_W-1:0] v;
    int unsigned      f;
    v = '0;
    for (int b = 0; b < ROW_W; b++) begin
      f    = row * ROW_W + b;
      v[b] = (f == 0) || (f >= frames);
    end
    return v;
  endfunction

endpackage

### rtl/pfa_if.sv
// pfa_in_if / pfa_out_if: valid-ready channels of the page frame allocator
// depends on pfa_pkg for the field widths
interface pfa_in_if;
  import pfa_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [FIDX_W-1:0]   dir_index;
  logic [AMOUNT_W-1:0] amount_bytes;

  modport source (output valid, output command, output dir_index, output amount_bytes,
                  input ready);
  modport sink   (input valid, input command, input dir_index, input amount_bytes,
                  output ready);
endinterface

interface pfa_out_if;
  import pfa_pkg::*;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [FIDX_W-1:0] frame_index;
  logic [FREE_W-1:0] free_frames;
  logic              tlb_invalidate;

  modport source (output valid, output ok, output frame_index, output free_frames,
                  output tlb_invalidate, input ready);
  modport sink   (input valid, input ok, input frame_index, input free_frames,
                  input tlb_invalidate, output ready);
endinterface

### rtl/pfa_ram.sv
// pfa_ram: generic single-port synchronous ram with registered read data
// no package dependency
module pfa_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/pfa_find.sv
// pfa_find: lowest clear bit of one used-bit row
// depends on pfa_pkg for find_t and the row width
module pfa_find (
  input  logic [pfa_pkg::ROW_W-1:0] used,
  output pfa_pkg::find_t            res
);
  import pfa_pkg::*;

  // priority encoder, lowest free position wins
  always_comb begin
    res.found = ~&used;
    res.pos   = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!used[i]) begin
        res.pos = ROW_SHIFT'(i);
      end
    end
  end

endmodule

### rtl/page_frame_allocator_4mb_core.sv
// page_frame_allocator_4mb_core: 4 MB frame allocator with a 1024-entry page directory
// depends on pfa_pkg, pfa_if, pfa_ram and pfa_find
//
// Usage
//   in_ch carries one command per transfer: check capacity, allocate or free.
//   out_ch returns exactly one result transfer for every command taken.
//   The directory (1024 x 14) and the used-bit map (rows of 32 frames) sit in
//   single-port rams; allocate and free are read-modify-write sequences on them.
//   A check goes from decode straight to the result; a free reads the directory
//   entry, then the map row if the frame lies inside the map; an allocate reads
//   and scans map rows in turn, at most ceil(FRAME_COUNT / 32) of them; each
//   row costs one ram read and one scan. One command is worked on at a time;
//   the next is taken once the result has been placed in the output register.
//   After reset a clearing pass over all 1024 directory entries writes the
//   directory and the map; in_ch.ready stays low for that time.
//   A result waits in the output register while out_ch.ready is low; the next
//   command may be taken and worked on, and holds its result until the
//   register frees.
module page_frame_allocator_4mb_core #(
  parameter int FRAME_COUNT = pfa_pkg::PFA_FRAME_COUNT
) (
  input  logic             clk,
  input  logic             rst_n,
  pfa_in_if.sink           in_ch,
  pfa_out_if.source        out_ch
);
  import pfa_pkg::*;

  localparam int ROWS   = (FRAME_COUNT + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W  = $clog2(FRAME_COUNT + 1);

  state_t state_r, state_nxt;

  logic [DIR_AW-1:0]   clr_r, clr_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [DIR_AW-1:0]   idx_r, idx_nxt;
  logic [AMOUNT_W-1:0] amt_r, amt_nxt;
  logic [ROW_AW-1:0]   row_r, row_nxt;
  logic [FIDX_W-1:0]   frame_r, frame_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic [FIDX_W-1:0]   res_frame_r, res_frame_nxt;
  logic                res_tlb_r, res_tlb_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [FIDX_W-1:0]   out_frame_r, out_frame_nxt;
  logic [FREE_W-1:0]   out_free_r, out_free_nxt;
  logic                out_tlb_r, out_tlb_nxt;

  // ram ports
  logic                dir_we;
  logic [DIR_AW-1:0]   dir_addr;
  logic [ENTRY_W-1:0]  dir_wdata, dir_rdata;
  logic                bm_we;
  logic [ROW_AW-1:0]   bm_addr;
  logic [ROW_W-1:0]    bm_wdata, bm_rdata;

  // datapath helpers
  logic [ROW_W-1:0]    scan_used;
  find_t               scan;
  logic [NEED_W-1:0]   need;
  logic [NEED_W-1:0]   cnt_ext;
  logic [FIDX_W-1:0]   ent_frame;
  logic [FIDX_W-1:0]   alloc_frame;
  logic [FREE_W-1:0]   free_sat;
  logic                out_room;

  pfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DIR_DEPTH),
    .ADDR_W(DIR_AW)
  ) u_dir_ram (
    .clk  (clk),
    .we   (dir_we),
    .addr (dir_addr),
    .wdata(dir_wdata),
    .rdata(dir_rdata)
  );

  pfa_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS),
    .ADDR_W(ROW_AW)
  ) u_map_ram (
    .clk  (clk),
    .we   (bm_we),
    .addr (bm_addr),
    .wdata(bm_wdata),
    .rdata(bm_rdata)
  );

  // frame 0 is never handed out, whatever its used bit says
  assign scan_used = (row_r == '0) ? (bm_rdata | ROW_W'(1)) : bm_rdata;

  pfa_find u_find (
    .used(scan_used),
    .res (scan)
  );

  // exact frame ceiling of the requested byte count
  assign need = NEED_W'(amt_r[AMOUNT_W-1:FRAME_SHIFT]) +
                NEED_W'(|amt_r[FRAME_SHIFT-1:0]);
  assign cnt_ext     = NEED_W'(count_r);
  assign free_sat    = (cnt_ext > NEED_W'(31)) ? FREE_W'(31) : cnt_ext[FREE_W-1:0];
  assign ent_frame   = dir_rdata[E_FRAME_SHIFT +: FIDX_W];
  assign alloc_frame = FIDX_W'({row_r, scan.pos});
  assign out_room    = !out_valid_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);

  // state and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= CNT_W'(FRAME_COUNT - 1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    amt_r       <= amt_nxt;
    row_r       <= row_nxt;
    frame_r     <= frame_nxt;
    res_ok_r    <= res_ok_nxt;
    res_frame_r <= res_frame_nxt;
    res_tlb_r   <= res_tlb_nxt;
    out_ok_r    <= out_ok_nxt;
    out_frame_r <= out_frame_nxt;
    out_free_r  <= out_free_nxt;
    out_tlb_r   <= out_tlb_nxt;
  end

  // sequencer: next state, ram control and result build
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    amt_nxt       = amt_r;
    row_nxt       = row_r;
    frame_nxt     = frame_r;
    count_nxt     = count_r;
    res_ok_nxt    = res_ok_r;
    res_frame_nxt = res_frame_r;
    res_tlb_nxt   = res_tlb_r;
    out_ok_nxt    = out_ok_r;
    out_frame_nxt = out_frame_r;
    out_free_nxt  = out_free_r;
    out_tlb_nxt   = out_tlb_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    dir_we    = 1'b0;
    dir_addr  = idx_r;
    dir_wdata = '0;
    bm_we     = 1'b0;
    bm_addr   = row_r;
    bm_wdata  = bm_rdata;

    unique case (state_r)
      S_CLEAR: begin
        dir_we   = 1'b1;
        dir_addr = clr_r;
        if (clr_r == KERNEL_LOW_IDX || clr_r == KERNEL_HIGH_IDX) begin
          dir_wdata = E_KERNEL;
        end
        bm_addr  = clr_r[ROW_AW-1:0];
        bm_we    = (int'(clr_r) < ROWS);
        bm_wdata = row_init(int'(clr_r), FRAME_COUNT);
        clr_nxt  = clr_r + DIR_AW'(1);
        if (clr_r == DIR_AW'(DIR_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt       = in_ch.command;
          idx_nxt       = in_ch.dir_index;
          amt_nxt       = in_ch.amount_bytes;
          res_ok_nxt    = 1'b0;
          res_frame_nxt = '0;
          res_tlb_nxt   = 1'b0;
          state_nxt     = S_DECODE;
        end
      end

      S_DECODE: begin
        case (cmd_r)
          CMD_CHECK: begin
            res_ok_nxt = (need <= cnt_ext);
            state_nxt  = S_RESULT;
          end
          CMD_ALLOC: begin
            row_nxt   = '0;
            state_nxt = S_A_READ;
          end
          CMD_FREE: begin
            state_nxt = S_F_READ;
          end
          default: begin
            state_nxt = S_RESULT;
          end
        endcase
      end

      // allocate: one map row read, then one scan per row
      S_A_READ: begin
        state_nxt = S_A_SCAN;
      end

      S_A_SCAN: begin
        if (scan.found) begin
          bm_we         = 1'b1;
          bm_wdata      = bm_rdata | (ROW_W'(1) << scan.pos);
          dir_we        = 1'b1;
          dir_wdata     = E_ALLOC | (ENTRY_W'(alloc_frame) << E_FRAME_SHIFT);
          if (count_r != '0) begin
            count_nxt = count_r - CNT_W'(1);
          end
          res_ok_nxt    = 1'b1;
          res_frame_nxt = alloc_frame;
          res_tlb_nxt   = 1'b1;
          state_nxt     = S_RESULT;
        end else if (row_r == ROW_AW'(ROWS - 1)) begin
          state_nxt = S_RESULT;
        end else begin
          row_nxt   = row_r + ROW_AW'(1);
          state_nxt = S_A_READ;
        end
      end

      // free: directory read, then map row read if the frame is inside the map
      S_F_READ: begin
        state_nxt = S_F_ENTRY;
      end

      S_F_ENTRY: begin
        if ((dir_rdata & E_PRESENT) == '0) begin
          state_nxt = S_RESULT;
        end else begin
          dir_we      = 1'b1;
          dir_wdata   = '0;
          res_ok_nxt  = 1'b1;
          res_tlb_nxt = 1'b1;
          frame_nxt   = ent_frame;
          if (int'(ent_frame) < FRAME_COUNT) begin
            row_nxt   = ROW_AW'(ent_frame >> ROW_SHIFT);
            bm_addr   = ROW_AW'(ent_frame >> ROW_SHIFT);
            state_nxt = S_F_BITMAP;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end

      S_F_BITMAP: begin
        if (bm_rdata[frame_r[ROW_SHIFT-1:0]]) begin
          bm_we         = 1'b1;
          bm_wdata      = bm_rdata & ~(ROW_W'(1) << frame_r[ROW_SHIFT-1:0]);
          count_nxt     = count_r + CNT_W'(1);
          res_frame_nxt = frame_r;
        end
        state_nxt = S_RESULT;
      end

      // hand the result to the output register once it is free
      S_RESULT: begin
        if (out_room) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_frame_nxt = res_frame_r;
          out_free_nxt  = free_sat;
          out_tlb_nxt   = res_tlb_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.ok             = out_ok_r;
  assign out_ch.frame_index    = out_frame_r;
  assign out_ch.free_frames    = out_free_r;
  assign out_ch.tlb_invalidate = out_tlb_r;

endmodule

### rtl/pfa_chk.sv
// pfa_chk: port-level checks of the page frame allocator and its bind
// depends on pfa_pkg for field widths; attached to page_frame_allocator_4mb_core
module pfa_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_ok,
  input logic [pfa_pkg::FIDX_W-1:0] out_frame_index,
  input logic [pfa_pkg::FREE_W-1:0] out_free_frames,
  input logic                      out_tlb_invalidate
);
  import pfa_pkg::*;

  // a waiting result holds until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) &&
      $stable(out_frame_index) && $stable(out_free_frames) && $stable(out_tlb_invalidate))
    else $error("result changed while stalled");

  // the clearing pass keeps the input closed right after reset
  a_clear_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during clearing pass");

  // one command at a time: input closes after each transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while busy");

  // an invalidate is only raised on a successful command
  a_tlb_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tlb_invalidate |-> out_ok)
    else $error("tlb invalidate without success");

  // a reported frame means the directory entry changed
  a_frame_tlb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_frame_index != '0) |-> out_ok && out_tlb_invalidate)
    else $error("frame reported without directory change");

endmodule

bind page_frame_allocator_4mb_core pfa_chk u_pfa_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_ok            (out_ch.ok),
  .out_frame_index   (out_ch.frame_index),
  .out_free_frames   (out_ch.free_frames),
  .out_tlb_invalidate(out_ch.tlb_invalidate)
);
